@@ rtl/v4n_pkg.sv @@
// v4n_pkg: widths, stage counts and shared types for the vector normalizer.
// No dependencies; every other file imports it.
`default_nettype none

package v4n_pkg;

  localparam int COMPONENT_WIDTH = 16;
  localparam int LANES           = 4;
  localparam int FRAC_BITS       = 8;
  localparam int UNIT_WIDTH      = 16;
  localparam int UNIT_SHIFT      = UNIT_WIDTH - 1 + FRAC_BITS;
  localparam int SQ_WIDTH        = 2 * COMPONENT_WIDTH;
  localparam int SQUARED_WIDTH   = 2 * COMPONENT_WIDTH + 1;
  localparam int LENGTH_WIDTH    = COMPONENT_WIDTH + 1;
  localparam int RAD_WIDTH       = 2 * ((SQUARED_WIDTH + 2 * FRAC_BITS + 1) / 2);
  localparam int ROOT_WIDTH      = RAD_WIDTH / 2;
  localparam int SQRT_STEPS      = ROOT_WIDTH;
  localparam int SQREM_WIDTH     = ROOT_WIDTH + 3;
  localparam int NUM_WIDTH       = COMPONENT_WIDTH + UNIT_SHIFT;
  localparam int QUO_WIDTH       = UNIT_WIDTH;
  localparam int DIV_STEPS       = QUO_WIDTH;
  localparam int DSH_WIDTH       = ROOT_WIDTH + QUO_WIDTH;
  localparam int PIPE_STAGES     = 2 + SQRT_STEPS + DIV_STEPS;

  localparam logic [UNIT_WIDTH-1:0] UNIT_POS_MAX = {1'b0, {(UNIT_WIDTH-1){1'b1}}};
  localparam logic [UNIT_WIDTH-1:0] UNIT_NEG_MAG = {1'b1, {(UNIT_WIDTH-1){1'b0}}};

  typedef logic [COMPONENT_WIDTH-1:0] mag_t;
  typedef logic [ROOT_WIDTH-1:0]      root_t;
  typedef logic [QUO_WIDTH-1:0]       quo_t;

  // side data that rides along the square-root stages
  typedef struct packed {
    mag_t [LANES-1:0]         mag;
    logic [LANES-1:0]         neg;
    logic [SQUARED_WIDTH-1:0] sum;
  } sqrt_side_t;

  // side data that rides along the divider stages
  typedef struct packed {
    logic [LANES-1:0]         neg;
    logic [SQUARED_WIDTH-1:0] sum;
    root_t                    root;
  } div_side_t;

endpackage

`default_nettype wire

@@ rtl/v4n_if.sv @@
// v4n_in_if / v4n_out_if: valid/ready word channels of the vector normalizer.
// Depends on v4n_pkg.
`default_nettype none

interface v4n_in_if import v4n_pkg::*; ();
  logic                              valid;
  logic                              ready;
  logic signed [COMPONENT_WIDTH-1:0] comp_x;
  logic signed [COMPONENT_WIDTH-1:0] comp_y;
  logic signed [COMPONENT_WIDTH-1:0] comp_z;
  logic signed [COMPONENT_WIDTH-1:0] comp_w;

  modport source (output valid, comp_x, comp_y, comp_z, comp_w, input ready);
  modport sink   (input valid, comp_x, comp_y, comp_z, comp_w, output ready);
endinterface

interface v4n_out_if import v4n_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic signed [UNIT_WIDTH-1:0]   unit_x;
  logic signed [UNIT_WIDTH-1:0]   unit_y;
  logic signed [UNIT_WIDTH-1:0]   unit_z;
  logic signed [UNIT_WIDTH-1:0]   unit_w;
  logic [SQUARED_WIDTH-1:0]       squared_length;
  logic [LENGTH_WIDTH-1:0]        vector_length;
  logic                           zero_vector;

  modport source (output valid, unit_x, unit_y, unit_z, unit_w, squared_length,
                  vector_length, zero_vector, input ready);
  modport sink   (input valid, unit_x, unit_y, unit_z, unit_w, squared_length,
                  vector_length, zero_vector, output ready);
endinterface

`default_nettype wire

@@ rtl/v4n_lane_front.sv @@
// v4n_lane_front: one lane's magnitude, sign and square, registered.
// Depends on v4n_pkg.
`default_nettype none

module v4n_lane_front import v4n_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [COMPONENT_WIDTH-1:0] comp,
  output logic                            neg_r,
  output mag_t                            mag_r,
  output logic [SQ_WIDTH-1:0]             sq_r
);

  logic neg_nxt;
  mag_t mag_nxt;

  assign neg_nxt = comp[COMPONENT_WIDTH-1];
  assign mag_nxt = neg_nxt ? (~comp + mag_t'(1)) : comp;

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r <= neg_nxt;
      mag_r <= mag_nxt;
      sq_r  <= SQ_WIDTH'(mag_nxt) * SQ_WIDTH'(mag_nxt);
    end
  end

endmodule

`default_nettype wire

@@ rtl/v4n_sqrt_pipe.sv @@
// v4n_sqrt_pipe: floor(sqrt(sum * 2^16)), one root bit per stage.
// Depends on v4n_pkg.
`default_nettype none

module v4n_sqrt_pipe import v4n_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [SQUARED_WIDTH-1:0] sum,
  output root_t                         root
);

  root_t                  rt_r [SQRT_STEPS];
  logic [SQREM_WIDTH-1:0] rm_r [SQRT_STEPS];
  logic [RAD_WIDTH-1:0]   rd_r [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    root_t                  rt_in;
    logic [SQREM_WIDTH-1:0] rm_in;
    logic [RAD_WIDTH-1:0]   rd_in;
    logic [SQREM_WIDTH-1:0] rm_sh;
    logic [SQREM_WIDTH-1:0] trial;
    logic                   ge;

    if (k == 0) begin : g_first
      assign rt_in = '0;
      assign rm_in = '0;
      assign rd_in = RAD_WIDTH'({sum, {(2*FRAC_BITS){1'b0}}});
    end else begin : g_next
      assign rt_in = rt_r[k-1];
      assign rm_in = rm_r[k-1];
      assign rd_in = rd_r[k-1];
    end

    always_comb begin
      rm_sh = {rm_in[SQREM_WIDTH-3:0], rd_in[RAD_WIDTH-1 -: 2]};
      trial = SQREM_WIDTH'({rt_in, 2'b01});
      ge    = (rm_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rm_r[k] <= ge ? (rm_sh - trial) : rm_sh;
        rt_r[k] <= {rt_in[ROOT_WIDTH-2:0], ge};
        rd_r[k] <= {rd_in[RAD_WIDTH-3:0], 2'b00};
      end
    end
  end

  assign root = rt_r[SQRT_STEPS-1];

endmodule

`default_nettype wire

@@ rtl/v4n_div_lane.sv @@
// v4n_div_lane: one lane's restoring divide (mag << 23) / root, one bit per stage.
// Depends on v4n_pkg.
`default_nettype none

module v4n_div_lane import v4n_pkg::*; (
  input  wire logic clk,
  input  wire logic en,
  input  wire mag_t mag,
  input  wire root_t root,
  output quo_t      quo
);

  logic [NUM_WIDTH-1:0] rem_r [DIV_STEPS];
  root_t                d_r   [DIV_STEPS];
  quo_t                 q_r   [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    logic [NUM_WIDTH-1:0] rem_in;
    root_t                d_in;
    quo_t                 q_in;
    logic [DSH_WIDTH-1:0] dsh;
    logic                 ge;

    if (j == 0) begin : g_first
      assign rem_in = {mag, {UNIT_SHIFT{1'b0}}};
      assign d_in   = root;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign d_in   = d_r[j-1];
      assign q_in   = q_r[j-1];
    end

    always_comb begin
      dsh = DSH_WIDTH'(d_in) << (QUO_WIDTH - 1 - j);
      ge  = (DSH_WIDTH'(rem_in) >= dsh);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= ge ? NUM_WIDTH'(DSH_WIDTH'(rem_in) - dsh) : rem_in;
        d_r[j]   <= d_in;
        q_r[j]   <= {q_in[QUO_WIDTH-2:0], ge};
      end
    end
  end

  assign quo = q_r[DIV_STEPS-1];

endmodule

`default_nettype wire

@@ rtl/vec4_length_normalize.sv @@
// vec4_length_normalize: Euclidean length and Q1.15 unit vector of a Q8.8 vector.
// Depends on v4n_pkg, v4n_if, v4n_lane_front, v4n_sqrt_pipe, v4n_div_lane.
`default_nettype none

// Takes one word per clock while the pipeline does not stall: four signed Q8.8
// components. Returns one word per input with the squared length (Q17.16), the
// length floor(sqrt) in Q9.8 and the unit vector in Q1.15, truncated toward zero
// and saturated (+1.0 reads 32767, -1.0 reads -32768). An all-zero vector sets
// zero_vector and gives zero units. From acceptance to out valid a word passes
// one lane stage (magnitude and square), one merge stage (sum of squares), 25
// square-root stages (one root bit each) and 16 divider stages (one quotient bit
// each, four lanes side by side), then the output register. The whole pipeline
// stalls only when the output register holds a word that is not taken and the
// last stage carries a word; bubbles keep moving otherwise. No state survives an
// item.

module vec4_length_normalize import v4n_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  v4n_in_if.sink     in_s,
  v4n_out_if.source  out_m
);

  localparam int LAST = PIPE_STAGES - 1;

  // ---- flow control ----
  logic                   en;
  logic                   load;
  logic [PIPE_STAGES-1:0] vld_r;
  logic                   out_valid_r;

  assign en         = !vld_r[LAST] || !out_valid_r || out_m.ready;
  assign load       = vld_r[LAST] && (!out_valid_r || out_m.ready);
  assign in_s.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_STAGES-2:0], in_s.valid};
    end
  end

  // ---- lanes: magnitude and square ----
  logic [COMPONENT_WIDTH-1:0] comp [LANES];
  logic [LANES-1:0]           neg_a;
  mag_t [LANES-1:0]           mag_a;
  logic [SQ_WIDTH-1:0]        sq_a [LANES];

  assign comp[0] = in_s.comp_x;
  assign comp[1] = in_s.comp_y;
  assign comp[2] = in_s.comp_z;
  assign comp[3] = in_s.comp_w;

  for (genvar l = 0; l < LANES; l++) begin : g_front
    v4n_lane_front u_front (
      .clk   (clk),
      .en    (en),
      .comp  (comp[l]),
      .neg_r (neg_a[l]),
      .mag_r (mag_a[l]),
      .sq_r  (sq_a[l])
    );
  end

  // ---- merge: sum of squares ----
  sqrt_side_t b_r;
  sqrt_side_t b_nxt;

  always_comb begin
    b_nxt.mag = mag_a;
    b_nxt.neg = neg_a;
    b_nxt.sum = SQUARED_WIDTH'(sq_a[0]) + SQUARED_WIDTH'(sq_a[1])
              + SQUARED_WIDTH'(sq_a[2]) + SQUARED_WIDTH'(sq_a[3]);
  end

  always_ff @(posedge clk) begin
    if (en) b_r <= b_nxt;
  end

  // ---- square root, side data delayed alongside ----
  root_t      root;
  sqrt_side_t sd_r [SQRT_STEPS];

  v4n_sqrt_pipe u_sqrt (
    .clk  (clk),
    .en   (en),
    .sum  (b_r.sum),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= b_r;
      for (int i = 1; i < SQRT_STEPS; i++) sd_r[i] <= sd_r[i-1];
    end
  end

  // ---- divide lanes ----
  sqrt_side_t sd_last;
  quo_t       quo [LANES];
  div_side_t  dd_r [DIV_STEPS];
  div_side_t  dd_nxt;

  assign sd_last = sd_r[SQRT_STEPS-1];

  for (genvar l = 0; l < LANES; l++) begin : g_div
    v4n_div_lane u_div (
      .clk  (clk),
      .en   (en),
      .mag  (sd_last.mag[l]),
      .root (root),
      .quo  (quo[l])
    );
  end

  always_comb begin
    dd_nxt.neg  = sd_last.neg;
    dd_nxt.sum  = sd_last.sum;
    dd_nxt.root = root;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dd_r[0] <= dd_nxt;
      for (int i = 1; i < DIV_STEPS; i++) dd_r[i] <= dd_r[i-1];
    end
  end

  // ---- saturate, sign and output register ----
  div_side_t             dd_last;
  logic                  zero;
  logic [UNIT_WIDTH-1:0] unit_nxt [LANES];
  logic [UNIT_WIDTH-1:0] unit_r   [LANES];
  logic [SQUARED_WIDTH-1:0] sqlen_r;
  logic [LENGTH_WIDTH-1:0]  len_r;
  logic                     zero_r;

  assign dd_last = dd_r[DIV_STEPS-1];
  assign zero    = (dd_last.sum == '0);

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (zero) begin
        unit_nxt[l] = '0;
      end else if (dd_last.neg[l]) begin
        unit_nxt[l] = (quo[l] > UNIT_NEG_MAG) ? UNIT_NEG_MAG : (~quo[l] + quo_t'(1));
      end else begin
        unit_nxt[l] = (quo[l] > UNIT_POS_MAX) ? UNIT_POS_MAX : quo[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_m.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int l = 0; l < LANES; l++) unit_r[l] <= unit_nxt[l];
      sqlen_r <= dd_last.sum;
      len_r   <= LENGTH_WIDTH'(dd_last.root >> FRAC_BITS);
      zero_r  <= zero;
    end
  end

  assign out_m.valid          = out_valid_r;
  assign out_m.unit_x         = unit_r[0];
  assign out_m.unit_y         = unit_r[1];
  assign out_m.unit_z         = unit_r[2];
  assign out_m.unit_w         = unit_r[3];
  assign out_m.squared_length = sqlen_r;
  assign out_m.vector_length  = len_r;
  assign out_m.zero_vector    = zero_r;

endmodule

`default_nettype wire

@@ rtl/v4n_checker.sv @@
// v4n_checker: port-level checks on the vector normalizer, bound to the top.
// Depends on v4n_pkg and vec4_length_normalize.
`default_nettype none

module v4n_checker import v4n_pkg::*; (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [UNIT_WIDTH-1:0]          out_unit_x,
  input wire logic [UNIT_WIDTH-1:0]          out_unit_y,
  input wire logic [UNIT_WIDTH-1:0]          out_unit_z,
  input wire logic [UNIT_WIDTH-1:0]          out_unit_w,
  input wire logic [SQUARED_WIDTH-1:0]       out_squared_length,
  input wire logic [LENGTH_WIDTH-1:0]        out_vector_length,
  input wire logic                           out_zero_vector
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out word dropped while stalled");

  a_zero_units: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_vector |-> out_unit_x == '0 && out_unit_y == '0
      && out_unit_z == '0 && out_unit_w == '0 && out_vector_length == '0)
    else $error("zero word with nonzero fields");

  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_squared_length == '0 |-> out_zero_vector)
    else $error("zero sum without zero flag");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_zero_vector |-> out_vector_length != '0
      && out_squared_length != '0)
    else $error("nonzero vector with zero length");

endmodule

bind vec4_length_normalize v4n_checker u_v4n_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_m.valid),
  .out_ready          (out_m.ready),
  .out_unit_x         (out_m.unit_x),
  .out_unit_y         (out_m.unit_y),
  .out_unit_z         (out_m.unit_z),
  .out_unit_w         (out_m.unit_w),
  .out_squared_length (out_m.squared_length),
  .out_vector_length  (out_m.vector_length),
  .out_zero_vector    (out_m.zero_vector)
);

`default_nettype wire

@@ sim/tb_vec4_length_normalize_if.sv @@
// Testbench-side copy point for the normalizer channels: the RTL interfaces are used as is.
// Depends on v4n_pkg; holds a small helper package for the bench.
`timescale 1ns / 100ps

package v4n_tb_pkg;
  import v4n_pkg::*;

  typedef struct packed {
    logic signed [COMPONENT_WIDTH-1:0] x, y, z, w;
  } vec_word_t;

  typedef struct packed {
    logic signed [UNIT_WIDTH-1:0] ux, uy, uz, uw;
    logic [SQUARED_WIDTH-1:0]     sq;
    logic [LENGTH_WIDTH-1:0]      len;
    logic                         zero;
  } norm_word_t;
endpackage

@@ sim/tb_vec4_length_normalize.sv @@
// tb_vec4_length_normalize: drives vectors into the normalizer and checks every output word
// against a bit-exact predictor. Depends on v4n_pkg, v4n_if, v4n_tb_pkg and the RTL top.
`timescale 1ns / 100ps

module tb_vec4_length_normalize;
  import v4n_pkg::*;
  import v4n_tb_pkg::*;

  localparam int WATCHDOG = 20000;
  localparam int HOLD_CYCLES = 150;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  v4n_in_if  in_ch ();
  v4n_out_if out_ch ();

  vec4_length_normalize uut (.clk(clk), .rst_n(rst_n), .in_s(in_ch.sink), .out_m(out_ch.source));

  // idle percentages, set per phase
  int src_idle = 0;
  int snk_idle = 0;
  bit long_stall = 1'b0; // request for one long receiver stall
  int hold_cnt = 0;      // cycles of the long stall done so far
  int errors = 0;
  int row_errors = 0;
  int quiet = 0;
  norm_word_t expected_q[$];

  // floor(sqrt(n)), n below 2^50
  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 50;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic norm_word_t normalize(vec_word_t v);
    norm_word_t o;
    logic signed [COMPONENT_WIDTH-1:0] c[4];
    longint unsigned m[4], s, root, q;
    logic signed [UNIT_WIDTH-1:0] u[4];
    c = '{v.x, v.y, v.z, v.w};
    s = 0;
    for (int i = 0; i < 4; i++) begin
      m[i] = c[i] < 0 ? longint'(-int'(c[i])) : longint'(c[i]);
      s += m[i] * m[i];
    end
    o = '0;
    o.sq = s[SQUARED_WIDTH-1:0];
    if (s == 0) begin
      o.zero = 1'b1;
      return o;
    end
    root = isqrt(s << 16);
    o.len = LENGTH_WIDTH'(root >> FRAC_BITS);
    for (int i = 0; i < 4; i++) begin
      q = (m[i] << 23) / root;
      if (c[i] < 0) u[i] = (q > 32768) ? 16'sh8000 : UNIT_WIDTH'(-longint'(q));
      else          u[i] = (q > 32767) ? 16'sh7fff : UNIT_WIDTH'(q);
    end
    o.ux = u[0]; o.uy = u[1]; o.uz = u[2]; o.uw = u[3];
    return o;
  endfunction

  // receiver: random stalls, plus one long hold-off counted here when asked
  always @(posedge clk) begin
    if (long_stall && hold_cnt < HOLD_CYCLES) begin
      out_ch.ready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  // output checker and watchdog
  always @(posedge clk) begin
    norm_word_t got, exp_w;
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet > WATCHDOG) begin
        $display("tb_vec4_length_normalize: FAIL");
        $finish;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.unit_x, out_ch.unit_y, out_ch.unit_z, out_ch.unit_w,
                out_ch.squared_length, out_ch.vector_length, out_ch.zero_vector};
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word %h", $time, got);
        end else begin
          exp_w = expected_q.pop_front();
          if (got !== exp_w) begin
            errors++;
            $display("%0t: mismatch expected ux=%0d uy=%0d uz=%0d uw=%0d sq=%0d len=%0d z=%0b",
                     $time, exp_w.ux, exp_w.uy, exp_w.uz, exp_w.uw, exp_w.sq, exp_w.len,
                     exp_w.zero);
            $display("%0t:          actual   ux=%0d uy=%0d uz=%0d uw=%0d sq=%0d len=%0d z=%0b",
                     $time, got.ux, got.uy, got.uz, got.uw, got.sq, got.len, got.zero);
          end
        end
      end
    end
  end

  // directed rows; known results only where obvious, others go to the predictor
  typedef struct {
    vec_word_t  v;
    bit         known;
    norm_word_t r;
  } row_t;
  row_t rows[$];

  function automatic vec_word_t rand_vec();
    vec_word_t v;
    int sel;
    sel = $urandom_range(9);
    v = {$urandom, $urandom};
    // small magnitudes often, to reach the saturation and fine-root corners
    if (sel < 3) begin
      v.x = $signed(8'($urandom)); v.y = $signed(8'($urandom));
      v.z = $signed(8'($urandom)); v.w = $signed(8'($urandom));
    end else if (sel == 3) begin
      v = '0;
      case ($urandom_range(3))
        0: v.x = COMPONENT_WIDTH'($urandom);
        1: v.y = COMPONENT_WIDTH'($urandom);
        2: v.z = COMPONENT_WIDTH'($urandom);
        default: v.w = COMPONENT_WIDTH'($urandom);
      endcase
    end else if (sel == 4) begin
      v = '0;
    end
    return v;
  endfunction

  // send one word, holding valid across back-to-back items
  task automatic send(vec_word_t v);
    while (src_idle != 0 && $urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.comp_x <= v.x; in_ch.comp_y <= v.y; in_ch.comp_z <= v.z; in_ch.comp_w <= v.w;
    do @(posedge clk); while (!in_ch.ready);
    expected_q.push_back(normalize(v));
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.comp_x = '0; in_ch.comp_y = '0; in_ch.comp_z = '0; in_ch.comp_w = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero vector
    rows.push_back('{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1,
                     '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 33'd0, 17'd0, 1'b1}});
    // exact +1.0 / -1.0 on an axis
    rows.push_back('{'{16'sd256, 16'sd0, 16'sd0, 16'sd0}, 1,
                     '{16'sh7fff, 16'sd0, 16'sd0, 16'sd0, 33'd65536, 17'd256, 1'b0}});
    rows.push_back('{'{16'sd0, -16'sd256, 16'sd0, 16'sd0}, 1,
                     '{16'sd0, 16'sh8000, 16'sd0, 16'sd0, 33'd65536, 17'd256, 1'b0}});
    // all components at the negative extreme: largest sum
    rows.push_back('{'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}, 1,
                     '{-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384,
                       33'h1_0000_0000, 17'h10000, 1'b0}});
    rows.push_back('{'{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff}, 0, '0});
    rows.push_back('{'{16'sd0, 16'sd0, 16'sd0, 16'sh8000}, 0, '0});
    rows.push_back('{'{16'sd0, 16'sd0, 16'sh7fff, 16'sd0}, 0, '0});
    rows.push_back('{'{16'sd1, 16'sd0, 16'sd0, 16'sd0}, 0, '0});
    rows.push_back('{'{-16'sd1, -16'sd1, -16'sd1, -16'sd1}, 0, '0});
    rows.push_back('{'{16'sd1, 16'sh8000, 16'sd1, 16'sh7fff}, 0, '0});
    rows.push_back('{'{16'sh5555, -16'sh5556, 16'sh2aaa, -16'sh2aab}, 0, '0});

    foreach (rows[i]) begin
      send(rows[i].v);
      if (rows[i].known && expected_q[$] !== rows[i].r) begin
        row_errors++;
        $display("%0t: table row %0d: expected %h predictor %h", $time, i, rows[i].r,
                 expected_q[$]);
      end
    end

    // phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      src_idle = (ph == 1 || ph == 3) ? (ph == 3 ? 34 : 57) : 0;
      snk_idle = (ph == 2 || ph == 3) ? (ph == 3 ? 34 : 57) : 0;
      if (ph == 0) long_stall = 1'b1;   // sender keeps offering while the pipe fills
      for (int n = 0; n < 185; n++) begin
        send(rand_vec());
        // stretches with no idling inside each phase
        if (n == 120) begin src_idle = 0; snk_idle = 0; end
      end
    end
    in_ch.valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0 && row_errors == 0) $display("tb_vec4_length_normalize: PASS");
    else $display("tb_vec4_length_normalize: FAIL");
    $finish;
  end
endmodule
